@@ hdl/iida_pkg.sv @@
package iida_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CNT_W     = 7;
    localparam int POS_W     = 6;
    localparam int DATA_W    = 32;

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_EDIT   = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADIDX = 2'd3;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [2:0]              mode;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } t_in_req;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]        item_count;
    } t_out_rsp;

endpackage

@@ hdl/indexed_insert_delete_array_top.sv @@
// Ordered array of signed 32-bit words with indexed insert and delete.
// Requests arrive on the input channel (i_in_valid / o_in_ready, payload
// i_in_req) and each one produces exactly one response on the output channel
// (o_out_valid / i_out_ready, payload o_out_rsp) carrying a status code, the
// value read and the item count after the operation.
// The storage is a row of DEPTH cells; every cell shifts, loads or holds in
// the same cycle, so the whole operation completes at the accepting edge.
// Responses are valid in the cycle after acceptance. Throughput is one request
// per cycle while responses are taken, set by the single response register,
// refilled in the same cycle it is drained. When the receiver stalls, the
// response is held and o_in_ready drops until it is taken. Reset clears the
// item count and o_out_valid and sets capacity to 64; stored words are not
// cleared and need no clearing pass. The user must write capacity through
// i_cfg_we / i_cfg_wdata only while no request is in flight; the block does
// not enforce this. The effective limit is the lesser of capacity and DEPTH.
module indexed_insert_delete_array_top
    import iida_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_req          i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_rsp         o_out_rsp
);

    localparam int XW_A = $clog2(DEPTH) + 1;
    localparam int XW   = (XW_A > CNT_W) ? XW_A : CNT_W;
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    logic [CNT_W-1:0]  r_capacity;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic              r_out_valid;
    t_out_rsp          r_out_rsp;
    t_out_rsp          n_out_rsp;

    logic              w_accept;
    logic [XW-1:0]     w_pos;
    logic [XW-1:0]     w_fill;
    logic [XW-1:0]     w_cap;
    logic [XW-1:0]     w_limit;
    logic              w_full;
    logic              w_wr;
    logic              w_shift_up;
    logic              w_shift_down;
    logic [XW-1:0]     w_wr_idx;
    logic [DATA_W-1:0] w_rd;
    logic [DATA_W-1:0] w_cell [DEPTH];

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    assign w_pos   = XW'(i_in_req.position);
    assign w_fill  = XW'(r_fill);
    assign w_cap   = XW'(r_capacity);
    assign w_limit = (w_cap > DEPTH_X) ? DEPTH_X : w_cap;
    assign w_full  = w_fill >= w_limit;

    always_comb begin
        w_rd = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (XW'(i) == w_pos) begin
                w_rd = w_cell[i];
            end
        end
    end

    always_comb begin
        w_wr         = 1'b0;
        w_shift_up   = 1'b0;
        w_shift_down = 1'b0;
        w_wr_idx     = w_pos;
        n_fill       = r_fill;
        n_out_rsp.status     = ST_DONE;
        n_out_rsp.read_value = '0;
        unique case (i_in_req.mode) inside
            MODE_APPEND: begin
                if (w_full) begin
                    n_out_rsp.status = ST_FULL;
                end else begin
                    w_wr     = 1'b1;
                    w_wr_idx = w_fill;
                    n_fill   = r_fill + CNT_W'(1);
                end
            end
            MODE_INSERT: begin
                if (w_full) begin
                    n_out_rsp.status = ST_FULL;
                end else if (w_pos > w_fill) begin
                    n_out_rsp.status = ST_BADIDX;
                end else begin
                    w_wr       = 1'b1;
                    w_shift_up = 1'b1;
                    n_fill     = r_fill + CNT_W'(1);
                end
            end
            MODE_DELETE, MODE_EDIT, MODE_READ: begin
                if (r_fill == '0) begin
                    n_out_rsp.status = ST_EMPTY;
                end else if (w_pos >= w_fill) begin
                    n_out_rsp.status = ST_BADIDX;
                end else if (i_in_req.mode == MODE_DELETE) begin
                    w_shift_down = 1'b1;
                    n_fill       = r_fill - CNT_W'(1);
                end else if (i_in_req.mode == MODE_EDIT) begin
                    w_wr = 1'b1;
                end else begin
                    n_out_rsp.read_value = w_rd;
                end
            end
            default: begin
                n_out_rsp.status = ST_BADIDX;
            end
        endcase
        n_out_rsp.item_count = n_fill;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        iida_cell #(
            .INDEX (g),
            .XW    (XW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_wr         (w_wr && w_accept),
            .i_shift_up   (w_shift_up && w_accept),
            .i_shift_down (w_shift_down && w_accept),
            .i_wr_idx     (w_wr_idx),
            .i_pos        (w_pos),
            .i_fill       (w_fill),
            .i_value      (i_in_req.value),
            .i_left       (w_left),
            .i_right      (w_right),
            .o_data       (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

@@ hdl/iida_cell.sv @@
module iida_cell
    import iida_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int XW    = 8
) (
    input  logic              i_clk,
    input  logic              i_wr,
    input  logic              i_shift_up,
    input  logic              i_shift_down,
    input  logic [XW-1:0]     i_wr_idx,
    input  logic [XW-1:0]     i_pos,
    input  logic [XW-1:0]     i_fill,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data
);

    localparam logic [XW-1:0] IDX    = XW'(INDEX);
    localparam logic [XW-1:0] IDX_P1 = XW'(INDEX + 1);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // Insert opens a gap at the write index by taking from the lower neighbor;
    // delete closes the gap by taking from the upper neighbor.
    always_comb begin
        n_data = r_data;
        if (i_wr && IDX == i_wr_idx) begin
            n_data = i_value;
        end else if (i_shift_up && IDX > i_wr_idx && IDX <= i_fill) begin
            n_data = i_left;
        end else if (i_shift_down && IDX >= i_pos && IDX_P1 < i_fill) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ bench/iida_array_checker.sv @@
module iida_array_checker
    import iida_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_req          i_in_req,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_rsp         i_out_rsp,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_fill
);

    logic signed [DATA_W-1:0] stored_words [DEPTH_DEF];
    int unsigned              word_count;
    logic [CNT_W-1:0]         capacity_reg;
    t_out_rsp                 pending_rsps [$];
    int                       mismatches;
    t_out_rsp                 want;

    assign o_fail_count = mismatches;

    initial begin
        mismatches   = 0;
        word_count   = 0;
        capacity_reg = CAP_RESET;
        o_pending    = 0;
        o_fill       = 0;
    end

    // Applies one request to the shadow array and returns the response it must produce.
    function automatic t_out_rsp apply_request(t_in_req req);
        t_out_rsp    rsp;
        int unsigned lim;
        int unsigned i;
        rsp        = '0;
        rsp.status = ST_DONE;
        lim        = (capacity_reg > DEPTH_DEF) ? DEPTH_DEF : capacity_reg;
        case (req.mode)
            MODE_APPEND: begin
                if (word_count >= lim) begin
                    rsp.status = ST_FULL;
                end else begin
                    stored_words[word_count] = req.value;
                    word_count++;
                end
            end
            MODE_INSERT: begin
                if (word_count >= lim) begin
                    rsp.status = ST_FULL;
                end else if (req.position > word_count) begin
                    rsp.status = ST_BADIDX;
                end else begin
                    for (i = word_count; i > req.position; i--) begin
                        stored_words[i] = stored_words[i-1];
                    end
                    stored_words[req.position] = req.value;
                    word_count++;
                end
            end
            MODE_DELETE, MODE_EDIT, MODE_READ: begin
                if (word_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (req.position >= word_count) begin
                    rsp.status = ST_BADIDX;
                end else if (req.mode == MODE_DELETE) begin
                    for (i = req.position; i + 1 < word_count; i++) begin
                        stored_words[i] = stored_words[i+1];
                    end
                    word_count--;
                end else if (req.mode == MODE_EDIT) begin
                    stored_words[req.position] = req.value;
                end else begin
                    rsp.read_value = stored_words[req.position];
                end
            end
            default: begin
                rsp.status = ST_BADIDX;
            end
        endcase
        rsp.item_count = word_count[CNT_W-1:0];
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_count   = 0;
            capacity_reg = CAP_RESET;
            pending_rsps.delete();
        end else begin
            // Responses are retired before the request of the same edge is predicted.
            if (i_out_valid && i_out_ready) begin
                if (pending_rsps.size() == 0) begin
                    $display("%0t: response with none expected: status %0d value %0d count %0d",
                             $time, i_out_rsp.status, i_out_rsp.read_value,
                             i_out_rsp.item_count);
                    mismatches++;
                end else begin
                    want = pending_rsps.pop_front();
                    if (i_out_rsp.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, i_out_rsp.status);
                        mismatches++;
                    end
                    if (i_out_rsp.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %0d got %0d",
                                 $time, want.read_value, i_out_rsp.read_value);
                        mismatches++;
                    end
                    if (i_out_rsp.item_count !== want.item_count) begin
                        $display("%0t: item_count expected %0d got %0d",
                                 $time, want.item_count, i_out_rsp.item_count);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                capacity_reg = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                pending_rsps.push_back(apply_request(i_in_req));
            end
        end
        o_pending <= pending_rsps.size();
        o_fill    <= word_count;
    end

endmodule

@@ bench/tb_indexed_insert_delete_array_top.sv @@
module tb_indexed_insert_delete_array_top;
    import iida_pkg::*;

    localparam logic [2:0] MODE_SPARE_A = 3'd5;
    localparam logic [2:0] MODE_SPARE_B = 3'd6;
    localparam logic [2:0] MODE_SPARE_C = 3'd7;
    localparam int         NUM_PHASES   = 8;
    localparam int         PHASE_ITEMS  = 175;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = CAP_RESET;
    logic             i_in_valid  = 1'b0;
    t_in_req          i_in_req    = '0;
    logic             i_out_ready = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out_rsp         o_out_rsp;
    int               fail_count;
    int               rsp_pending;
    int               fill_seen;
    int               burst_left  = 0;

    // Capacity per phase and the share of appends and inserts in percent.
    int capacity_plan [NUM_PHASES] = '{1, 0, 127, 3, 64, 17, 65, 64};
    int grow_plan     [NUM_PHASES] = '{50, 50, 75, 10, 60, 50, 75, 40};

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    indexed_insert_delete_array_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    iida_array_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_rsp    (o_out_rsp),
        .o_fail_count (fail_count),
        .o_pending    (rsp_pending),
        .o_fill       (fill_seen)
    );

    // Offers one request, holds it until accepted, then may pause before the next one.
    task automatic issue(input logic [2:0] mode, input int pos, input logic [31:0] val);
        i_in_valid        <= 1'b1;
        i_in_req.mode     <= mode;
        i_in_req.position <= pos[POS_W-1:0];
        i_in_req.value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 30);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rsp_pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input int cap);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_request(input int grow_pct);
        int          pick;
        int          pos_hi;
        logic [2:0]  mode;
        logic [31:0] val;
        int          pos;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            mode = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
        end else if (pick < 3 + grow_pct) begin
            mode = ($urandom_range(0, 1) == 0) ? MODE_APPEND : MODE_INSERT;
        end else begin
            pick = $urandom_range(0, 9);
            mode = (pick < 5) ? MODE_DELETE : (pick < 8) ? MODE_EDIT : MODE_READ;
        end
        // Most positions fall between zero and one past the fill level so that shifts and edits succeed.
        pos_hi = (fill_seen + 1 > 63) ? 63 : fill_seen + 1;
        pos = ($urandom_range(0, 4) != 0) ? $urandom_range(0, pos_hi) : $urandom_range(0, 63);
        case ($urandom_range(0, 19))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = 32'hffff_ffff;
            3:       val = 32'h0000_0000;
            default: val = $urandom;
        endcase
        issue(mode, pos, val);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Operations on an empty array, then a small list built from both ends.
        issue(MODE_DELETE, 0, 32'd1);
        issue(MODE_EDIT, 0, 32'd2);
        issue(MODE_READ, 63, 32'd3);
        issue(MODE_INSERT, 1, 32'd4);
        issue(MODE_INSERT, 0, 32'h8000_0000);
        issue(MODE_APPEND, 0, 32'h7fff_ffff);
        issue(MODE_INSERT, 2, 32'hffff_ffff);
        issue(MODE_INSERT, 1, 32'h0000_0000);
        issue(MODE_READ, 0, 32'd0);
        issue(MODE_READ, 1, 32'd0);
        issue(MODE_READ, 2, 32'd0);
        issue(MODE_READ, 3, 32'd0);
        issue(MODE_EDIT, 3, 32'h5a5a_5a5a);
        issue(MODE_READ, 3, 32'hffff_ffff);
        issue(MODE_READ, 4, 32'd0);
        issue(MODE_EDIT, 63, 32'd9);
        issue(MODE_DELETE, 63, 32'd0);
        issue(MODE_INSERT, 63, 32'd7);
        issue(MODE_SPARE_A, 0, 32'hffff_ffff);
        issue(MODE_SPARE_B, 63, 32'd0);
        issue(MODE_SPARE_C, 1, 32'h1234_5678);
        issue(MODE_DELETE, 0, 32'd0);
        issue(MODE_DELETE, 2, 32'd0);
        issue(MODE_READ, 1, 32'd0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(capacity_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_request(grow_plan[p]);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("indexed_insert_delete_array_top: match");
        end else begin
            $display("indexed_insert_delete_array_top: mismatch");
        end
        $finish;
    end

    // The receiver alternates between free flow, random stalls and long hold-offs.
    initial begin
        int seg;
        int kind;
        int span;
        seg = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            kind = $urandom_range(0, 9);
            if (seg == 1 || kind == 0) begin
                span = $urandom_range(40, 80);
                repeat (span) begin
                    i_out_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end else if (kind <= 3) begin
                span = $urandom_range(10, 80);
                repeat (span) begin
                    i_out_ready <= 1'b1;
                    @(posedge i_clk);
                end
            end else begin
                span = $urandom_range(20, 100);
                repeat (span) begin
                    i_out_ready <= ($urandom_range(0, 2) != 0);
                    @(posedge i_clk);
                end
            end
            seg++;
        end
    end

    initial begin
        #20000000;
        $display("indexed_insert_delete_array_top: mismatch");
        $finish;
    end

endmodule

@@ indexed_insert_delete_array_top.f @@
hdl/iida_pkg.sv
hdl/iida_cell.sv
hdl/indexed_insert_delete_array_top.sv
bench/iida_array_checker.sv
bench/tb_indexed_insert_delete_array_top.sv
